>>> hw/rtl/mdd_pkg.sv
// Shared types, codes and constants for the multi-order difference decoder.
`default_nettype none
package mdd_pkg;

  // Default sizing, handed to the top level as parameter defaults
  localparam int MAX_SATS_DEF  = 64;
  localparam int MAX_TYPES_DEF = 32;
  localparam int MAX_ORDER_DEF = 5;

  // Field widths fixed by the item format
  localparam int VAL_W    = 48;
  localparam int SLOT_W   = 6;
  localparam int TYPE_W   = 5;
  localparam int ORD_W    = 4;
  localparam int META_W   = 2 * ORD_W;

  // Order code kept in both order fields of a blank entry
  localparam logic [ORD_W-1:0] ORD_BLANK = 4'd15;
  localparam logic [META_W-1:0] META_BLANK = {ORD_BLANK, ORD_BLANK};

  // Accepted value window: strictly between LIM_LOW and LIM_HIGH
  localparam logic signed [VAL_W-1:0] LIM_HIGH = 48'sd10000000000000;
  localparam logic signed [VAL_W-1:0] LIM_LOW  = -48'sd1000000000000;

  // Front-to-back queue, depth must be a power of two
  localparam int FQ_DEPTH = 2;
  localparam int FQ_AW    = $clog2(FQ_DEPTH);

  typedef enum logic [1:0] {
    OP_DIFF  = 2'd0,
    OP_ARC   = 2'd1,
    OP_BLANK = 2'd2,
    OP_EOE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NEW_SAT    = 3'd1,
    ST_PREV_BLANK = 3'd2,
    ST_ORDER_HIGH = 3'd3,
    ST_RANGE      = 3'd4
  } status_t;

  // Item classes decided by the front
  typedef enum logic [2:0] {
    K_EOE,
    K_RANGE,
    K_BLANK,
    K_ARC_BAD,
    K_ARC,
    K_NO_OLD,
    K_OLD_RANGE,
    K_DIFF
  } kind_t;

  typedef struct packed {
    op_t                     op;
    logic [SLOT_W-1:0]       slot;
    logic                    has_old;
    logic [SLOT_W-1:0]       old_slot;
    logic [TYPE_W-1:0]       type_index;
    logic [ORD_W-1:0]        arc_order_in;
    logic signed [VAL_W-1:0] diff_value;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    blank;
    status_t                 status;
  } out_item_t;

  typedef struct packed {
    kind_t                   kind;
    logic [SLOT_W-1:0]       slot;
    logic [SLOT_W-1:0]       old_slot;
    logic [TYPE_W-1:0]       type_index;
    logic [ORD_W-1:0]        arc_ord;
    logic signed [VAL_W-1:0] diff_value;
  } q_item_t;

endpackage
`default_nettype wire

>>> hw/rtl/multi_order_difference_decoder.sv
// Top level of the multi-order difference decoder: front end, queue and back end.
//
// Usage: items arrive on in_valid/in_stall/in_data and each gives exactly one
// result on out_valid/out_stall/out_data. A transfer happens at a rising edge
// with valid high and stall low on that channel.
// The front classifies each item and places it in a two-entry queue; the back
// end works on one item at a time against two entry stores (orders per entry
// and difference terms per entry), both single-port-read RAMs.
// Back end states per item: S_IDLE pops it, S_EXEC handles end of epoch, blank
// field, arc start and the errors decided by the front, then S_FIN; a difference
// checks its previous entry's orders in S_META (stopping there if it is blank),
// then per term reads in S_TRD and adds in S_TACC on the term RAM, then S_DONE.
// The queue keeps taking items while the back end works or a result waits;
// in_stall rises only when the queue is full.
// Reset clears the queue, the sequencer, the output valid and the bank select;
// store contents are undefined until written, so there is no clearing pass.
// When out_stall is high the result holds in the output register and the back
// end holds its next result until the register frees.
`default_nettype none
module multi_order_difference_decoder #(
  parameter int MAX_SATS  = mdd_pkg::MAX_SATS_DEF,
  parameter int MAX_TYPES = mdd_pkg::MAX_TYPES_DEF,
  parameter int MAX_ORDER = mdd_pkg::MAX_ORDER_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mdd_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output mdd_pkg::out_item_t out_data
);
  import mdd_pkg::*;

  logic    q_valid;
  logic    q_pop;
  q_item_t q_head;

  // Classification and queue
  mdd_front #(
    .MAX_SATS  (MAX_SATS),
    .MAX_TYPES (MAX_TYPES),
    .MAX_ORDER (MAX_ORDER)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_head   (q_head)
  );

  // Execution against the entry stores
  mdd_back #(
    .MAX_SATS  (MAX_SATS),
    .MAX_TYPES (MAX_TYPES),
    .MAX_ORDER (MAX_ORDER)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_head    (q_head),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

>>> hw/rtl/mdd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mdd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

>>> hw/rtl/mdd_front.sv
// Front end: takes input transfers, classifies them and queues them for the back end.
`default_nettype none
module mdd_front #(
  parameter int MAX_SATS  = mdd_pkg::MAX_SATS_DEF,
  parameter int MAX_TYPES = mdd_pkg::MAX_TYPES_DEF,
  parameter int MAX_ORDER = mdd_pkg::MAX_ORDER_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  mdd_pkg::in_item_t in_data,
  output logic              q_valid,
  input  logic              q_pop,
  output mdd_pkg::q_item_t  q_head
);
  import mdd_pkg::*;

  q_item_t          q_mem_r [FQ_DEPTH];
  logic [FQ_AW-1:0] wptr_r, wptr_nxt;
  logic [FQ_AW-1:0] rptr_r, rptr_nxt;
  logic [FQ_AW:0]   cnt_r, cnt_nxt;
  logic             push;
  q_item_t          cls;

  // Classify the incoming item
  always_comb begin
    cls.slot       = in_data.slot;
    cls.old_slot   = in_data.old_slot;
    cls.type_index = in_data.type_index;
    cls.arc_ord    = in_data.arc_order_in;
    cls.diff_value = in_data.diff_value;
    if (in_data.op == OP_EOE) begin
      cls.kind = K_EOE;
    end else if (int'(in_data.slot) >= MAX_SATS || int'(in_data.type_index) >= MAX_TYPES) begin
      cls.kind = K_RANGE;
    end else begin
      case (in_data.op)
        OP_BLANK: cls.kind = K_BLANK;
        OP_ARC: begin
          cls.kind = (int'(in_data.arc_order_in) > MAX_ORDER) ? K_ARC_BAD : K_ARC;
        end
        OP_DIFF: begin
          if (!in_data.has_old) begin
            cls.kind = K_NO_OLD;
          end else if (int'(in_data.old_slot) >= MAX_SATS) begin
            cls.kind = K_OLD_RANGE;
          end else begin
            cls.kind = K_DIFF;
          end
        end
        default: cls.kind = K_EOE;
      endcase
    end
  end

  // Queue control
  assign in_stall = (cnt_r == (FQ_AW+1)'(FQ_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign q_head   = q_mem_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = q_pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r;
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wptr_r] <= cls;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/mdd_back.sv
// Back end: sequencer that updates the entry stores and produces one result per item.
`default_nettype none
module mdd_back #(
  parameter int MAX_SATS  = mdd_pkg::MAX_SATS_DEF,
  parameter int MAX_TYPES = mdd_pkg::MAX_TYPES_DEF,
  parameter int MAX_ORDER = mdd_pkg::MAX_ORDER_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_pop,
  input  mdd_pkg::q_item_t   q_head,
  output logic               out_valid,
  input  logic               out_stall,
  output mdd_pkg::out_item_t out_data
);
  import mdd_pkg::*;

  localparam int NTERMS = MAX_ORDER + 1;
  localparam int NENTRY = 2 * MAX_SATS * MAX_TYPES;
  localparam int EW     = $clog2(NENTRY);
  localparam int NTW    = NENTRY * NTERMS;
  localparam int TW     = $clog2(NTW);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_META,
    S_TRD,
    S_TACC,
    S_DONE,
    S_FIN
  } state_t;

  state_t             state_r, state_nxt;
  logic               bank_r, bank_nxt;
  q_item_t            item_r, item_nxt;
  logic [EW-1:0]      cur_r, cur_nxt;
  logic [EW-1:0]      prev_r, prev_nxt;
  logic [TW-1:0]      cur_base_r, cur_base_nxt;
  logic [TW-1:0]      prev_base_r, prev_base_nxt;
  logic [ORD_W-1:0]   arc_r, arc_nxt;
  logic [ORD_W-1:0]   onew_r, onew_nxt;
  logic               off_r, off_nxt;
  logic [ORD_W-1:0]   k_r, k_nxt;
  logic [VAL_W-1:0]   acc_r, acc_nxt;
  out_item_t          res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;

  logic               bank_old;
  logic [EW-1:0]      cur_idx, prev_idx;
  logic               out_free;

  logic               meta_we;
  logic [META_W-1:0]  meta_wdata;
  logic [META_W-1:0]  meta_rdata;
  logic               term_we;
  logic [TW-1:0]      term_waddr;
  logic [VAL_W-1:0]   term_wdata;
  logic [TW-1:0]      term_raddr;
  logic [VAL_W-1:0]   term_rdata;

  logic [ORD_W-1:0]   m_ord, m_arc, a_lim, o_lim, o_new;
  logic               grow;
  logic [VAL_W-1:0]   sum;
  logic [ORD_W-1:0]   k_inc;

  // Entry stores: order pair per entry, and the difference terms
  mdd_ram #(.WIDTH(META_W), .DEPTH(NENTRY)) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (cur_r),
    .wdata (meta_wdata),
    .raddr (prev_r),
    .rdata (meta_rdata)
  );

  mdd_ram #(.WIDTH(VAL_W), .DEPTH(NTW)) u_term_ram (
    .clk   (clk),
    .we    (term_we),
    .waddr (term_waddr),
    .wdata (term_wdata),
    .raddr (term_raddr),
    .rdata (term_rdata)
  );

  // Entry addressing for the queue head
  assign bank_old = ~bank_r;
  assign cur_idx  = EW'((int'(bank_r) * MAX_SATS + int'(q_head.slot)) * MAX_TYPES
                        + int'(q_head.type_index));
  assign prev_idx = EW'((int'(bank_old) * MAX_SATS + int'(q_head.old_slot)) * MAX_TYPES
                        + int'(q_head.type_index));
  assign term_raddr = prev_base_r + TW'(k_r) + TW'(off_r);

  // Order bookkeeping for the previous entry
  assign m_ord = meta_rdata[META_W-1:ORD_W];
  assign m_arc = meta_rdata[ORD_W-1:0];
  assign a_lim = (int'(m_arc) > MAX_ORDER) ? ORD_W'(MAX_ORDER) : m_arc;
  assign o_lim = (m_ord > a_lim) ? a_lim : m_ord;
  assign grow  = (o_lim < a_lim);
  assign o_new = grow ? o_lim + 1'b1 : o_lim;

  assign sum      = acc_r + term_rdata;
  assign k_inc    = k_r + 1'b1;
  assign out_free = !out_valid_r || !out_stall;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    bank_nxt      = bank_r;
    item_nxt      = item_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    cur_base_nxt  = cur_base_r;
    prev_base_nxt = prev_base_r;
    arc_nxt       = arc_r;
    onew_nxt      = onew_r;
    off_nxt       = off_r;
    k_nxt         = k_r;
    acc_nxt       = acc_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    q_pop         = 1'b0;
    meta_we       = 1'b0;
    meta_wdata    = META_BLANK;
    term_we       = 1'b0;
    term_waddr    = cur_base_r;
    term_wdata    = acc_r;

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop         = 1'b1;
          item_nxt      = q_head;
          cur_nxt       = cur_idx;
          prev_nxt      = prev_idx;
          cur_base_nxt  = TW'(int'(cur_idx) * NTERMS);
          prev_base_nxt = TW'(int'(prev_idx) * NTERMS);
          state_nxt     = S_EXEC;
        end
      end

      S_EXEC: begin
        res_nxt.value  = '0;
        res_nxt.blank  = 1'b0;
        res_nxt.status = ST_OK;
        acc_nxt        = item_r.diff_value;
        state_nxt      = S_FIN;
        case (item_r.kind)
          K_EOE: begin
            bank_nxt      = ~bank_r;
            res_nxt.blank = 1'b1;
          end
          K_RANGE: res_nxt.status = ST_RANGE;
          K_BLANK: begin
            meta_we       = 1'b1;
            res_nxt.blank = 1'b1;
          end
          K_ARC_BAD: begin
            meta_we        = 1'b1;
            res_nxt.status = ST_ORDER_HIGH;
          end
          K_ARC: begin
            meta_we       = 1'b1;
            meta_wdata    = {ORD_W'(0), item_r.arc_ord};
            term_we       = 1'b1;
            term_wdata    = item_r.diff_value;
            res_nxt.value = item_r.diff_value;
          end
          K_NO_OLD: begin
            meta_we        = 1'b1;
            res_nxt.status = ST_NEW_SAT;
          end
          K_OLD_RANGE: begin
            meta_we        = 1'b1;
            res_nxt.status = ST_RANGE;
          end
          K_DIFF: state_nxt = S_META;
          default: state_nxt = S_FIN;
        endcase
      end

      // Previous entry's orders are on the read port now
      S_META: begin
        if (m_arc == ORD_BLANK) begin
          meta_we        = 1'b1;
          res_nxt.status = ST_PREV_BLANK;
          state_nxt      = S_FIN;
        end else begin
          arc_nxt    = a_lim;
          onew_nxt   = o_new;
          off_nxt    = !grow;
          k_nxt      = '0;
          term_we    = 1'b1;
          term_wdata = item_r.diff_value;
          state_nxt  = (o_new == '0) ? S_DONE : S_TRD;
        end
      end

      // Fetch the previous term k (or k+1 once the arc order is reached)
      S_TRD: state_nxt = S_TACC;

      // Add it into the chain and store the new term
      S_TACC: begin
        acc_nxt    = sum;
        term_we    = 1'b1;
        term_waddr = cur_base_r + TW'(k_inc);
        term_wdata = sum;
        k_nxt      = k_inc;
        state_nxt  = (k_inc == onew_r) ? S_DONE : S_TRD;
      end

      S_DONE: begin
        meta_we    = 1'b1;
        meta_wdata = {onew_r, arc_r};
        if ($signed(acc_r) >= LIM_HIGH || $signed(acc_r) <= LIM_LOW) begin
          res_nxt.status = ST_RANGE;
        end else begin
          res_nxt.value = acc_r;
        end
        state_nxt = S_FIN;
      end

      // Hand the result to the output register
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bank_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bank_r      <= bank_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_r      <= item_nxt;
    cur_r       <= cur_nxt;
    prev_r      <= prev_nxt;
    cur_base_r  <= cur_base_nxt;
    prev_base_r <= prev_base_nxt;
    arc_r       <= arc_nxt;
    onew_r      <= onew_nxt;
    off_r       <= off_nxt;
    k_r         <= k_nxt;
    acc_r       <= acc_nxt;
    res_r       <= res_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the multi-order difference decoder, with its own decode predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mdd_pkg::*;

  localparam int NSAT        = MAX_SATS_DEF;
  localparam int NTYP        = MAX_TYPES_DEF;
  localparam int MORD        = MAX_ORDER_DEF;
  localparam int NTERM       = MORD + 1;
  localparam int SAT_POOL    = 12;
  localparam int N_COLS      = 3;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 40;
  localparam int CYCLE_LIMIT = 400000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  multi_order_difference_decoder dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #10 clk = ~clk;

  // Predictor state: two banks of entries, each with orders and difference terms
  logic [VAL_W-1:0] term_mem [2][NSAT][NTYP][NTERM];
  logic [ORD_W-1:0] ord_mem  [2][NSAT][NTYP];
  logic [ORD_W-1:0] arc_mem  [2][NSAT][NTYP];
  bit               written  [2][NSAT][NTYP];
  bit               cur_bank = 1'b0;

  out_item_t pending_results [$];
  int        fail_count = 0;
  int        items_sent = 0;
  int        tx_idle_pct = 0;
  int        rx_idle_pct = 0;
  int        hold_reqs = 0;
  int        hold_taken = 0;
  int        hold_left = 0;
  longint    cycle_count = 0;

  // Epoch stream bookkeeping: slot of each satellite in the previous epoch
  int               sat_prev_slot [SAT_POOL] = '{default: -1};
  int               sat_cur_slot  [SAT_POOL];
  logic [TYPE_W-1:0] type_cols    [N_COLS];

  function automatic void blank_entry(bit bank, int s, int t);
    ord_mem[bank][s][t] = ORD_BLANK;
    arc_mem[bank][s][t] = ORD_BLANK;
    written[bank][s][t] = 1'b1;
  endfunction

  // Expected result of one item; updates the predictor state
  function automatic out_item_t decode_predict(in_item_t it);
    out_item_t               r;
    logic [VAL_W-1:0]        y [NTERM];
    logic signed [VAL_W-1:0] v;
    int                      o, a, s, t, ps;
    bit                      pb;
    r.value  = '0;
    r.blank  = 1'b0;
    r.status = ST_OK;
    s = it.slot;
    t = it.type_index;
    ps = it.old_slot;
    if (it.op == OP_EOE) begin
      cur_bank = ~cur_bank;
      r.blank = 1'b1;
      return r;
    end
    if (s >= NSAT || t >= NTYP) begin
      r.status = ST_RANGE;
      return r;
    end
    if (it.op == OP_BLANK) begin
      blank_entry(cur_bank, s, t);
      r.blank = 1'b1;
      return r;
    end
    if (it.op == OP_ARC) begin
      if (it.arc_order_in > MORD) begin
        blank_entry(cur_bank, s, t);
        r.status = ST_ORDER_HIGH;
        return r;
      end
      arc_mem[cur_bank][s][t] = it.arc_order_in;
      ord_mem[cur_bank][s][t] = '0;
      term_mem[cur_bank][s][t][0] = it.diff_value;
      written[cur_bank][s][t] = 1'b1;
      r.value = it.diff_value;
      return r;
    end
    // difference against the previous epoch's entry
    if (!it.has_old) begin
      blank_entry(cur_bank, s, t);
      r.status = ST_NEW_SAT;
      return r;
    end
    if (ps >= NSAT) begin
      blank_entry(cur_bank, s, t);
      r.status = ST_RANGE;
      return r;
    end
    pb = ~cur_bank;
    a = arc_mem[pb][ps][t];
    if (a == ORD_BLANK) begin
      blank_entry(cur_bank, s, t);
      r.status = ST_PREV_BLANK;
      return r;
    end
    o = ord_mem[pb][ps][t];
    if (a > MORD) a = MORD;
    if (o > a) o = a;
    y[0] = it.diff_value;
    if (o < a) begin
      // chain still growing: one more order this epoch
      o++;
      for (int k = 0; k < o; k++) y[k+1] = y[k] + term_mem[pb][ps][t][k];
    end else begin
      for (int k = 0; k < o; k++) y[k+1] = y[k] + term_mem[pb][ps][t][k+1];
    end
    for (int k = 0; k <= o; k++) term_mem[cur_bank][s][t][k] = y[k];
    ord_mem[cur_bank][s][t] = ORD_W'(o);
    arc_mem[cur_bank][s][t] = ORD_W'(a);
    written[cur_bank][s][t] = 1'b1;
    v = y[o];
    if (v >= LIM_HIGH || v <= LIM_LOW) begin
      r.status = ST_RANGE;
      return r;
    end
    r.value = y[o];
    return r;
  endfunction

  // Signed random value in +/- 2^(nbits-1), truncated to the field width
  function automatic logic [VAL_W-1:0] rand_value(int nbits);
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return VAL_W'($signed(raw) >>> (64 - nbits));
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    it.op           = op_t'($urandom_range(2));
    it.slot         = SLOT_W'($urandom_range(63));
    it.has_old      = 1'($urandom_range(1));
    it.old_slot     = SLOT_W'($urandom_range(63));
    it.type_index   = TYPE_W'($urandom_range(31));
    it.arc_order_in = ORD_W'($urandom_range(15));
    it.diff_value   = rand_value(48);
    return it;
  endfunction

  function automatic in_item_t mk_item(op_t op, int s, bit ho, int os, int t, int ao,
                                       logic [VAL_W-1:0] dv);
    in_item_t it;
    it.op           = op;
    it.slot         = SLOT_W'(s);
    it.has_old      = ho;
    it.old_slot     = SLOT_W'(os);
    it.type_index   = TYPE_W'(t);
    it.arc_order_in = ORD_W'(ao);
    it.diff_value   = dv;
    return it;
  endfunction

  // A difference must never read a previous-bank entry that was never written
  function automatic void legalize(inout in_item_t it);
    if (it.op == OP_DIFF && it.has_old && it.old_slot < NSAT && it.type_index < NTYP &&
        !written[~cur_bank][it.old_slot][it.type_index])
      it.has_old = 1'b0;
  endfunction

  // One input transfer, then record what it should produce
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.insert(pending_results.size(), decode_predict(it));
    items_sent++;
  endtask

  // Sender pauses until every result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // One epoch of differences and arc starts, with blanks, broken arcs and noise mixed in
  task automatic send_epoch();
    bit       slot_used [NSAT];
    int       n_here, sat, s, p, r;
    in_item_t it;
    foreach (sat_cur_slot[i]) sat_cur_slot[i] = -1;
    n_here = $urandom_range(1, 8);
    repeat (n_here) begin
      sat = $urandom_range(SAT_POOL - 1);
      if (sat_cur_slot[sat] < 0) begin
        do s = $urandom_range(NSAT - 1); while (slot_used[s]);
        slot_used[s] = 1'b1;
        sat_cur_slot[sat] = s;
      end
    end
    for (int i = 0; i < SAT_POOL; i++) begin
      if (sat_cur_slot[i] < 0) continue;
      p = sat_prev_slot[i];
      for (int c = 0; c < N_COLS; c++) begin
        if ($urandom_range(99) < 8) begin
          it = random_item();
          legalize(it);
          send_item(it);
        end
        it = random_item();
        it.slot = SLOT_W'(sat_cur_slot[i]);
        it.type_index = type_cols[c];
        r = $urandom_range(99);
        if (p >= 0 && r < 78) begin
          it.op = OP_DIFF;
          it.has_old = 1'b1;
          it.old_slot = SLOT_W'(p);
          r = $urandom_range(99);
          it.diff_value = rand_value(r < 80 ? 14 : (r < 97 ? 24 : 48));
        end else if ((p >= 0 && r < 86) || (p < 0 && r >= 93)) begin
          it.op = OP_BLANK;
        end else if ((p >= 0 && r < 95) || (p < 0 && r < 85)) begin
          it.op = OP_ARC;
          it.arc_order_in = ($urandom_range(99) < 10) ? ORD_W'($urandom_range(MORD + 1, 15))
                                                      : ORD_W'($urandom_range(MORD));
          it.diff_value = rand_value($urandom_range(99) < 90 ? 30 : 46);
        end else begin
          it.op = OP_DIFF;
          it.has_old = 1'b0;
        end
        legalize(it);
        send_item(it);
      end
    end
    it = random_item();
    it.op = OP_EOE;
    send_item(it);
    sat_prev_slot = sat_cur_slot;
    // occasionally an empty epoch, so the next one sees stale entries
    if ($urandom_range(99) < 4) begin
      it = random_item();
      it.op = OP_EOE;
      send_item(it);
      foreach (sat_prev_slot[i]) sat_prev_slot[i] = -1;
    end
  endtask

  // Field extremes, every op and every error path, over four epochs
  task automatic test_directed_cases();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    // epoch A, bank 0
    send_item(mk_item(OP_ARC, 0, 0, 0, 0, 5, 48'd100));
    send_item(mk_item(OP_ARC, 63, 1, 63, 31, 0, 48'h7FFF_FFFF_FFFF));
    send_item(mk_item(OP_ARC, 1, 0, 0, 2, 9, 48'd1));
    send_item(mk_item(OP_ARC, 4, 0, 0, 6, 15, '1));
    send_item(mk_item(OP_ARC, 2, 0, 0, 3, 1, 48'h8000_0000_0000));
    send_item(mk_item(OP_ARC, 10, 0, 0, 1, 0, 48'd0));
    send_item(mk_item(OP_BLANK, 3, 1, 63, 4, 15, '1));
    send_item(mk_item(OP_DIFF, 5, 0, 63, 5, 15, 48'd3));
    send_item(mk_item(OP_EOE, 63, 1, 63, 31, 15, '1));
    // epoch B: growth, range limits, blank predecessors, wrap past the limit
    send_item(mk_item(OP_DIFF, 5, 1, 0, 0, 0, 48'd7));
    send_item(mk_item(OP_DIFF, 6, 1, 63, 31, 0, 48'sd10000000000000));
    send_item(mk_item(OP_DIFF, 7, 1, 1, 2, 0, 48'd1));
    send_item(mk_item(OP_DIFF, 8, 1, 3, 4, 0, 48'd1));
    send_item(mk_item(OP_DIFF, 9, 1, 2, 3, 0, 48'd5));
    send_item(mk_item(OP_DIFF, 11, 1, 10, 1, 0, 48'sd9999999999999));
    send_item(mk_item(OP_DIFF, 12, 1, 10, 1, 0, -48'sd999999999999));
    send_item(mk_item(OP_DIFF, 13, 1, 10, 1, 0, -48'sd1000000000000));
    send_item(mk_item(OP_EOE, 0, 0, 0, 0, 0, '0));
    // epoch C
    send_item(mk_item(OP_DIFF, 0, 1, 5, 0, 0, -48'sd3));
    send_item(mk_item(OP_EOE, 0, 0, 0, 0, 0, '0));
    // epoch D: entries left over from epochs A and C
    send_item(mk_item(OP_DIFF, 20, 1, 2, 3, 0, '1));
    send_item(mk_item(OP_DIFF, 21, 1, 1, 2, 0, 48'd2));
    send_item(mk_item(OP_DIFF, 22, 1, 0, 0, 0, 48'd0));
    send_item(mk_item(OP_EOE, 0, 0, 0, 0, 0, '0));
    drain_results();
  endtask

  task automatic test_epoch_streams(input int n_items, input int tx_pct, input int rx_pct);
    int  goal;
    bit  dup;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int c = 0; c < N_COLS; c++) begin
      do begin
        type_cols[c] = TYPE_W'($urandom_range(NTYP - 1));
        dup = 1'b0;
        for (int j = 0; j < c; j++) if (type_cols[j] == type_cols[c]) dup = 1'b1;
      end while (dup);
    end
    goal = items_sent + n_items;
    while (items_sent < goal) send_epoch();
    drain_results();
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering
  task automatic test_output_hold();
    int goal;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_reqs++;
    goal = items_sent + 40;
    while (items_sent < goal) send_epoch();
    drain_results();
  endtask

  // Receiver stall: random, or a long hold on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_taken != hold_reqs) begin
      hold_taken++;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: value %0d blank %0d status %0d",
               out_data.value, out_data.blank, out_data.status);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.value !== want.value) begin
          $error("value mismatch: expected %0d, got %0d", want.value, out_data.value);
          fail_count++;
        end
        if (out_data.blank !== want.blank) begin
          $error("blank mismatch: expected %0d, got %0d", want.blank, out_data.blank);
          fail_count++;
        end
        if (out_data.status !== want.status) begin
          $error("status mismatch: expected %0d, got %0d", want.status, out_data.status);
          fail_count++;
        end
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_epoch_streams(350, 33, 71);
    test_epoch_streams(350, 71, 33);
    test_output_hold();
    test_epoch_streams(300, 0, 0);
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> multi_order_difference_decoder.f
hw/rtl/mdd_pkg.sv
hw/rtl/mdd_ram.sv
hw/rtl/mdd_front.sv
hw/rtl/mdd_back.sv
hw/rtl/multi_order_difference_decoder.sv
tb/tb_top.sv
